// File: src/psa_pkg.sv
// Shared constants and configuration register codes for the Pauli string amplitude block.
package psa_pkg;

	localparam int CFG_ADDR_BITS = 8;
	localparam int CFG_DATA_BITS = 16;
	localparam int MASK_BITS     = 16;
	localparam int COEFF_BITS    = 16;
	localparam int COEFF_FRAC    = 12;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_FLIP_MASK  = 8'd0,
		REG_PHASE_MASK = 8'd1,
		REG_COEFF_REAL = 8'd2,
		REG_COEFF_IMAG = 8'd3
	} cfg_reg_t;

	localparam logic signed [COEFF_BITS-1:0] COEFF_REAL_RESET = 16'sd4096;
	localparam logic signed [COEFF_BITS-1:0] COEFF_IMAG_RESET = 16'sd0;

endpackage

// File: src/psa_if.sv
// Handshake interfaces for the amplitude input, addend output and configuration channels.
interface psa_sample_if #(
	parameter int INDEX_BITS = 16,
	parameter int AMP_BITS   = 16
);
	logic                       valid;
	logic                       ready;
	logic [INDEX_BITS-1:0]      basis_index;
	logic signed [AMP_BITS-1:0] amp_real;
	logic signed [AMP_BITS-1:0] amp_imag;

	modport source (output valid, basis_index, amp_real, amp_imag, input ready);
	modport sink (input valid, basis_index, amp_real, amp_imag, output ready);
endinterface

interface psa_addend_if #(
	parameter int INDEX_BITS = 16,
	parameter int AMP_BITS   = 16
);
	logic                       valid;
	logic                       ready;
	logic [INDEX_BITS-1:0]      target_index;
	logic signed [AMP_BITS-1:0] add_real;
	logic signed [AMP_BITS-1:0] add_imag;
	logic                       saturated;

	modport source (output valid, target_index, add_real, add_imag, saturated, input ready);
	modport sink (input valid, target_index, add_real, add_imag, saturated, output ready);
endinterface

interface psa_cfg_if import psa_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic [CFG_ADDR_BITS-1:0] addr;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

// File: src/pauli_string_amplitude_apply.sv
// Top level: applies a scaled Pauli string to a stream of statevector amplitudes.
//
// The sample channel takes one word per cycle while sample.ready is high: a basis
// index and a complex Q1.15 amplitude. For every accepted word the addend channel
// delivers exactly one word: the target index (basis index XOR the flip mask), the
// addend coefficient times phase times amplitude, rounded and saturated, and a flag
// that is set when either part was clipped.
// The cfg channel writes the flip mask, phase mask and Q4.12 coefficient; it is
// always ready and must be used only while no word is in flight.
// The word passes four register stages: coefficient rotation, the four partial
// products, sum with rounding, and saturation. The throughput is one word per
// cycle while the receiver takes every word; each stage advances on its own enable.
// When the receiver stalls, each stage holds its word and the empty stages ahead
// still fill, so sample.ready falls only once all four stages are full.
// Reset empties the pipeline and loads the identity string with coefficient 1.0.
module pauli_string_amplitude_apply import psa_pkg::*; #(
	parameter int INDEX_BITS = 16,
	parameter int AMP_BITS   = 16
) (
	input logic          clk,
	input logic          arst_n,
	psa_cfg_if.sink      cfg,
	psa_sample_if.sink   sample,
	psa_addend_if.source addend
);

	localparam int RC_BITS  = COEFF_BITS + 1;
	localparam int PROD_W   = RC_BITS + AMP_BITS;
	localparam int SUM_W    = PROD_W + 1;
	localparam int RND_W    = SUM_W - COEFF_FRAC;
	localparam int WIDE_W   = INDEX_BITS + MASK_BITS;
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (COEFF_FRAC - 1);
	localparam logic signed [RND_W-1:0] SAT_HI =
		RND_W'((64'sd1 <<< (AMP_BITS - 1)) - 64'sd1);
	localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

	logic [MASK_BITS-1:0]         flip_q;
	logic [MASK_BITS-1:0]         phase_q;
	logic signed [COEFF_BITS-1:0] coeff_re_q;
	logic signed [COEFF_BITS-1:0] coeff_im_q;

	logic [WIDE_W-1:0]     flip_wide;
	logic [WIDE_W-1:0]     phase_wide;
	logic [INDEX_BITS-1:0] fm;
	logic [INDEX_BITS-1:0] pm;
	logic [1:0]            y_count;
	logic [1:0]            rot;
	logic signed [RC_BITS-1:0] cr_ext;
	logic signed [RC_BITS-1:0] ci_ext;
	logic signed [RC_BITS-1:0] cr_rot;
	logic signed [RC_BITS-1:0] ci_rot;

	logic en1, en2, en3, en4;

	logic                       v_s1;
	logic [INDEX_BITS-1:0]      idx_s1;
	logic signed [RC_BITS-1:0]  cr_s1;
	logic signed [RC_BITS-1:0]  ci_s1;
	logic signed [AMP_BITS-1:0] ar_s1;
	logic signed [AMP_BITS-1:0] ai_s1;

	logic                       v_s2;
	logic [INDEX_BITS-1:0]      idx_s2;
	logic signed [PROD_W-1:0]   p_rr_s2;
	logic signed [PROD_W-1:0]   p_ii_s2;
	logic signed [PROD_W-1:0]   p_ri_s2;
	logic signed [PROD_W-1:0]   p_ir_s2;

	logic                       v_s3;
	logic [INDEX_BITS-1:0]      idx_s3;
	logic signed [RND_W-1:0]    re_s3;
	logic signed [RND_W-1:0]    im_s3;

	logic                       v_s4;
	logic [INDEX_BITS-1:0]      idx_s4;
	logic signed [AMP_BITS-1:0] re_s4;
	logic signed [AMP_BITS-1:0] im_s4;
	logic                       sat_s4;

	logic signed [SUM_W-1:0] sum_re;
	logic signed [SUM_W-1:0] sum_im;
	logic signed [SUM_W-1:0] bias_re;
	logic signed [SUM_W-1:0] bias_im;
	logic signed [AMP_BITS-1:0] re_sat;
	logic signed [AMP_BITS-1:0] im_sat;
	logic re_clip;
	logic im_clip;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q     <= '0;
			phase_q    <= '0;
			coeff_re_q <= COEFF_REAL_RESET;
			coeff_im_q <= COEFF_IMAG_RESET;
		end else if (cfg.valid) begin
			case (cfg.addr)
				REG_FLIP_MASK:  flip_q     <= cfg.data;
				REG_PHASE_MASK: phase_q    <= cfg.data;
				REG_COEFF_REAL: coeff_re_q <= cfg.data;
				REG_COEFF_IMAG: coeff_im_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Masks cut to the index width and the number of Y letters modulo four.
	assign flip_wide  = WIDE_W'(flip_q);
	assign phase_wide = WIDE_W'(phase_q);
	assign fm         = flip_wide[INDEX_BITS-1:0];
	assign pm         = phase_wide[INDEX_BITS-1:0];

	always_comb begin
		y_count = 2'd0;
		for (int b = 0; b < INDEX_BITS; b++) begin
			y_count = y_count + {1'b0, fm[b] & pm[b]};
		end
	end

	// Stage 1: rotate the coefficient by the power of i.
	assign rot    = y_count + {^(sample.basis_index & pm), 1'b0};
	assign cr_ext = RC_BITS'(coeff_re_q);
	assign ci_ext = RC_BITS'(coeff_im_q);

	always_comb begin
		case (rot)
			2'd0: begin
				cr_rot = cr_ext;
				ci_rot = ci_ext;
			end
			2'd1: begin
				cr_rot = -ci_ext;
				ci_rot = cr_ext;
			end
			2'd2: begin
				cr_rot = -cr_ext;
				ci_rot = -ci_ext;
			end
			default: begin
				cr_rot = ci_ext;
				ci_rot = -cr_ext;
			end
		endcase
	end

	// A stage advances when it is empty or the stage after it takes its word.
	assign en4 = !v_s4 || addend.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sample.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= sample.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && sample.valid) begin
			idx_s1 <= sample.basis_index ^ fm;
			cr_s1  <= cr_rot;
			ci_s1  <= ci_rot;
			ar_s1  <= sample.amp_real;
			ai_s1  <= sample.amp_imag;
		end
	end

	// Stage 2: the four partial products.
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			idx_s2  <= idx_s1;
			p_rr_s2 <= cr_s1 * ar_s1;
			p_ii_s2 <= ci_s1 * ai_s1;
			p_ri_s2 <= cr_s1 * ai_s1;
			p_ir_s2 <= ci_s1 * ar_s1;
		end
	end

	// Stage 3: complex sums, then a floor shift after adding one half.
	assign sum_re  = SUM_W'(p_rr_s2) - SUM_W'(p_ii_s2);
	assign sum_im  = SUM_W'(p_ri_s2) + SUM_W'(p_ir_s2);
	assign bias_re = sum_re + ROUND_HALF;
	assign bias_im = sum_im + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			idx_s3 <= idx_s2;
			re_s3  <= bias_re[SUM_W-1:COEFF_FRAC];
			im_s3  <= bias_im[SUM_W-1:COEFF_FRAC];
		end
	end

	// Stage 4: saturation to the amplitude range.
	always_comb begin
		re_clip = 1'b0;
		im_clip = 1'b0;
		if (re_s3 > SAT_HI) begin
			re_sat  = SAT_HI[AMP_BITS-1:0];
			re_clip = 1'b1;
		end else if (re_s3 < SAT_LO) begin
			re_sat  = SAT_LO[AMP_BITS-1:0];
			re_clip = 1'b1;
		end else begin
			re_sat = re_s3[AMP_BITS-1:0];
		end
		if (im_s3 > SAT_HI) begin
			im_sat  = SAT_HI[AMP_BITS-1:0];
			im_clip = 1'b1;
		end else if (im_s3 < SAT_LO) begin
			im_sat  = SAT_LO[AMP_BITS-1:0];
			im_clip = 1'b1;
		end else begin
			im_sat = im_s3[AMP_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			idx_s4 <= idx_s3;
			re_s4  <= re_sat;
			im_s4  <= im_sat;
			sat_s4 <= re_clip || im_clip;
		end
	end

	assign addend.valid        = v_s4;
	assign addend.target_index = idx_s4;
	assign addend.add_real     = re_s4;
	assign addend.add_imag     = im_s4;
	assign addend.saturated    = sat_s4;

	// An empty first stage always takes a new word.
	assert property (@(posedge clk) disable iff (!arst_n) !v_s1 |-> sample.ready)
		else $error("sample channel stalled with an empty first stage");

	// A word in stage 1 moves on whenever stage 2 can take it.
	assert property (@(posedge clk) disable iff (!arst_n) (v_s1 && en2) |=> v_s2)
		else $error("word lost between stage 1 and stage 2");

	// A stalled output word is not overwritten by the word behind it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !addend.ready) |=> (v_s4 && $stable(idx_s4) && $stable(re_s4)))
		else $error("output word changed while stalled");

	// The clip flag only accompanies a part at a range limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && sat_s4) |-> (re_s4 == SAT_HI[AMP_BITS-1:0] || re_s4 == SAT_LO[AMP_BITS-1:0]
			|| im_s4 == SAT_HI[AMP_BITS-1:0] || im_s4 == SAT_LO[AMP_BITS-1:0]))
		else $error("saturated flag set with no part at a limit");

endmodule
